FILE: design/cls_pkg.sv
package cls_pkg;

  localparam int unsigned UnitW = 16;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAddrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  localparam logic [UnitW-1:0] U_END    = 16'h0000;
  localparam logic [UnitW-1:0] U_DQUOTE = 16'h0022;
  localparam logic [UnitW-1:0] U_SQUOTE = 16'h0027;
  localparam logic [UnitW-1:0] U_SLASH  = 16'h002F;
  localparam logic [UnitW-1:0] U_STAR   = 16'h002A;
  localparam logic [UnitW-1:0] U_NL     = 16'h000A;
  localparam logic [UnitW-1:0] U_BSLASH = 16'h005C;

  typedef enum logic [3:0] {
    M_NORMAL = 4'd0,
    M_SLASH  = 4'd1,
    M_LINE   = 4'd2,
    M_BLOCK  = 4'd3,
    M_BSTAR  = 4'd4,
    M_DQ     = 4'd5,
    M_DQ_ESC = 4'd6,
    M_SQ     = 4'd7,
    M_SQ_ESC = 4'd8,
    M_ERR    = 4'd9
  } mode_t;

  typedef enum logic [2:0] {
    ST_CHAR         = 3'd0,
    ST_END          = 3'd1,
    ST_UNCLOSED_LIT = 3'd2,
    ST_NL_LIT       = 3'd3,
    ST_UNCLOSED_CMT = 3'd4
  } status_t;

  typedef struct packed {
    logic [UnitW-1:0] out_char;
    status_t          status;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
    mode_t      mode;
  } step_t;

endpackage

FILE: design/cls_if.sv
interface cls_in_if;
  logic                        valid;
  logic                        ready;
  logic [cls_pkg::UnitW-1:0]   code_unit;

  modport source (output valid, output code_unit, input ready);
  modport sink (input valid, input code_unit, output ready);
endinterface

interface cls_out_if;
  logic                        valid;
  logic                        ready;
  logic [cls_pkg::UnitW-1:0]   out_char;
  logic [2:0]                  status;
  logic                        last;

  modport source (output valid, output out_char, output status, output last, input ready);
  modport sink (input valid, input out_char, input status, input last, output ready);
endinterface

FILE: design/cls_step.sv
module cls_step (
  input  cls_pkg::mode_t            mode,
  input  logic [cls_pkg::UnitW-1:0] unit,
  output cls_pkg::step_t            step
);

  cls_pkg::res_t  nrm_res;
  logic           nrm_emit;
  cls_pkg::mode_t nrm_mode;
  cls_pkg::res_t  slash_res;
  logic [cls_pkg::UnitW-1:0] quote;
  cls_pkg::mode_t esc_mode;

  // Handling of one unit in normal text.
  always_comb begin
    nrm_emit = 1'b1;
    nrm_res.out_char = unit;
    nrm_res.status = cls_pkg::ST_CHAR;
    nrm_res.last = 1'b0;
    nrm_mode = cls_pkg::M_NORMAL;
    priority if (unit == cls_pkg::U_END) begin
      nrm_res.out_char = '0;
      nrm_res.status = cls_pkg::ST_END;
    end else if (unit == cls_pkg::U_DQUOTE) begin
      nrm_mode = cls_pkg::M_DQ;
    end else if (unit == cls_pkg::U_SQUOTE) begin
      nrm_mode = cls_pkg::M_SQ;
    end else if (unit == cls_pkg::U_SLASH) begin
      nrm_emit = 1'b0;
      nrm_mode = cls_pkg::M_SLASH;
    end else begin
      nrm_mode = cls_pkg::M_NORMAL;
    end
  end

  always_comb begin
    slash_res.out_char = cls_pkg::U_SLASH;
    slash_res.status = cls_pkg::ST_CHAR;
    slash_res.last = 1'b0;
    quote = (mode == cls_pkg::M_SQ) ? cls_pkg::U_SQUOTE : cls_pkg::U_DQUOTE;
    esc_mode = (mode == cls_pkg::M_SQ) ? cls_pkg::M_SQ_ESC : cls_pkg::M_DQ_ESC;
  end

  always_comb begin
    step.cnt = 2'd0;
    step.r0.out_char = unit;
    step.r0.status = cls_pkg::ST_CHAR;
    step.r0.last = 1'b1;
    step.r1 = nrm_res;
    step.r1.last = 1'b1;
    step.mode = mode;
    unique case (mode)
      cls_pkg::M_SLASH: begin
        priority if (unit == cls_pkg::U_STAR) begin
          step.mode = cls_pkg::M_BLOCK;
        end else if (unit == cls_pkg::U_SLASH) begin
          step.mode = cls_pkg::M_LINE;
        end else begin
          step.cnt = 2'd2;
          step.r0 = slash_res;
          step.mode = nrm_mode;
        end
      end
      cls_pkg::M_LINE: begin
        priority if (unit == cls_pkg::U_END) begin
          step.cnt = 2'd1;
          step.r0.out_char = '0;
          step.r0.status = cls_pkg::ST_END;
          step.mode = cls_pkg::M_NORMAL;
        end else if (unit == cls_pkg::U_NL) begin
          step.mode = cls_pkg::M_NORMAL;
        end else begin
          step.mode = cls_pkg::M_LINE;
        end
      end
      cls_pkg::M_BLOCK, cls_pkg::M_BSTAR: begin
        priority if (unit == cls_pkg::U_END) begin
          step.cnt = 2'd1;
          step.r0.out_char = '0;
          step.r0.status = cls_pkg::ST_UNCLOSED_CMT;
          step.mode = cls_pkg::M_NORMAL;
        end else if (unit == cls_pkg::U_STAR) begin
          step.mode = cls_pkg::M_BSTAR;
        end else if (unit == cls_pkg::U_SLASH && mode == cls_pkg::M_BSTAR) begin
          step.mode = cls_pkg::M_NORMAL;
        end else begin
          step.mode = cls_pkg::M_BLOCK;
        end
      end
      cls_pkg::M_DQ, cls_pkg::M_SQ: begin
        step.cnt = 2'd1;
        priority if (unit == cls_pkg::U_END) begin
          step.r0.out_char = '0;
          step.r0.status = cls_pkg::ST_UNCLOSED_LIT;
          step.mode = cls_pkg::M_NORMAL;
        end else if (unit == cls_pkg::U_BSLASH) begin
          step.mode = esc_mode;
        end else if (unit == cls_pkg::U_NL) begin
          step.r0.out_char = '0;
          step.r0.status = cls_pkg::ST_NL_LIT;
          step.mode = cls_pkg::M_ERR;
        end else if (unit == quote) begin
          step.mode = cls_pkg::M_NORMAL;
        end else begin
          step.mode = mode;
        end
      end
      cls_pkg::M_DQ_ESC, cls_pkg::M_SQ_ESC: begin
        step.cnt = 2'd1;
        if (unit == cls_pkg::U_END) begin
          step.r0.out_char = '0;
          step.r0.status = cls_pkg::ST_UNCLOSED_LIT;
          step.mode = cls_pkg::M_NORMAL;
        end else begin
          step.mode = (mode == cls_pkg::M_DQ_ESC) ? cls_pkg::M_DQ : cls_pkg::M_SQ;
        end
      end
      cls_pkg::M_ERR: begin
        if (unit == cls_pkg::U_END) begin
          step.mode = cls_pkg::M_NORMAL;
        end
      end
      default: begin
        step.cnt = {1'b0, nrm_emit};
        step.r0 = nrm_res;
        step.r0.last = 1'b1;
        step.mode = nrm_mode;
      end
    endcase
  end

endmodule

FILE: design/cls_outq.sv
module cls_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  cls_pkg::step_t     step,
  input  logic               push,
  output logic               room,
  output logic               q_valid,
  input  logic               q_ready,
  output cls_pkg::res_t      q_head
);

  cls_pkg::res_t                 q_r [cls_pkg::QDepth];
  logic [cls_pkg::QAddrW-1:0]    wp_r, wp_nxt;
  logic [cls_pkg::QAddrW-1:0]    rp_r, rp_nxt;
  logic [cls_pkg::QCntW-1:0]     cnt_r, cnt_nxt;
  logic [1:0]                    push_cnt;
  logic                          pop;

  assign push_cnt = push ? step.cnt : 2'd0;
  assign pop = q_valid && q_ready;
  assign q_valid = (cnt_r != '0);
  assign q_head = q_r[rp_r];
  assign room = (cnt_r <= cls_pkg::QCntW'(cls_pkg::QDepth - 2));

  always_comb begin
    wp_nxt = wp_r + cls_pkg::QAddrW'(push_cnt);
    rp_nxt = rp_r + cls_pkg::QAddrW'(pop);
    cnt_nxt = cnt_r + cls_pkg::QCntW'(push_cnt) - cls_pkg::QCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      q_r[wp_r] <= step.r0;
    end
    if (push_cnt == 2'd2) begin
      q_r[wp_r + cls_pkg::QAddrW'(1)] <= step.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: design/comment_and_literal_stripper.sv
// Scans text one 16-bit code unit per transaction and removes block and line comments while
// keeping quoted literals intact; a zero unit ends the text and yields an end or error status
// unless a newline inside a literal has already reported its error. A new unit is accepted
// every cycle while the output queue has room for its results. Each unit is registered, then
// stepped through the scanner state, and its zero, one or two results enter a four-entry
// output queue from which the first result is presented. The output port delivers one result
// per cycle while the receiver is ready, so the two results of a unit that yields two (a held
// slash followed by another unit) leave one after the other, and the queue back-pressures the
// input when fewer than two entries are free.
module comment_and_literal_stripper (
  input  logic             clk,
  input  logic             rst_n,
  cls_in_if.sink           in_ch,
  cls_out_if.source        out_ch
);

  logic                      s1_valid_r, s1_valid_nxt;
  logic [cls_pkg::UnitW-1:0] s1_unit_r;
  cls_pkg::mode_t            mode_r, mode_nxt;
  cls_pkg::step_t            step;
  cls_pkg::res_t             head;
  logic                      room;
  logic                      proceed;
  logic                      accept;

  assign proceed = s1_valid_r && room;
  assign in_ch.ready = !s1_valid_r || proceed;
  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = accept ? 1'b1 : (proceed ? 1'b0 : s1_valid_r);
    mode_nxt = proceed ? step.mode : mode_r;
  end

  cls_step u_step (
    .mode (mode_r),
    .unit (s1_unit_r),
    .step (step)
  );

  cls_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .push    (proceed),
    .room    (room),
    .q_valid (out_ch.valid),
    .q_ready (out_ch.ready),
    .q_head  (head)
  );

  assign out_ch.out_char = head.out_char;
  assign out_ch.status = head.status;
  assign out_ch.last = head.last;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_unit_r <= in_ch.code_unit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      mode_r <= cls_pkg::M_NORMAL;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      mode_r <= mode_nxt;
    end
  end

endmodule

FILE: design/cls_checker.sv
module cls_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [cls_pkg::UnitW-1:0] out_char,
  input logic [2:0]                out_status,
  input logic                      out_last
);

  // Status-only results carry no character and always close their transaction group.
  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != cls_pkg::ST_CHAR |-> out_char == '0 && out_last)
    else $error("status result with character or without last");

  // The only result that is not last is a released slash.
  a_first_is_slash: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_char == cls_pkg::U_SLASH && out_status == cls_pkg::ST_CHAR)
    else $error("non-final result is not a slash");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= cls_pkg::ST_UNCLOSED_CMT)
    else $error("status code out of range");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind comment_and_literal_stripper cls_checker u_cls_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_char   (out_ch.out_char),
  .out_status (out_ch.status),
  .out_last   (out_ch.last)
);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int CycleLimit = 300000;
  localparam int MaxGap = 12;
  localparam int LongHold = 80;
  localparam int LongHoldAt = 300;
  localparam int DrainPauseAt = 1000;
  localparam int BurstFrom = 500;
  localparam int BurstTo = 700;
  localparam int TailCycles = 20;
  localparam int RandomUnits = 1800;

  typedef struct {
    logic [cls_pkg::UnitW-1:0] unit;
    int                        n_fixed;
    cls_pkg::res_t             r0;
    cls_pkg::res_t             r1;
  } unit_row_t;

  logic clk;
  logic rst_n;

  cls_in_if  in_ch ();
  cls_out_if out_ch ();

  comment_and_literal_stripper dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  unit_row_t      unit_rows[$];
  cls_pkg::res_t  stripped_q[$];
  cls_pkg::res_t  step_res[$];
  cls_pkg::mode_t scan_st;
  int             errors;
  int             got_cnt;
  int             cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void put_res(input logic [cls_pkg::UnitW-1:0] ch,
                                  input cls_pkg::status_t st);
    cls_pkg::res_t r;
    r.out_char = ch;
    r.status = st;
    r.last = 1'b0;
    step_res = {step_res, r};
  endfunction

  function automatic void plain_unit(input logic [cls_pkg::UnitW-1:0] u);
    if (u == cls_pkg::U_END) begin
      scan_st = cls_pkg::M_NORMAL;
      put_res(cls_pkg::U_END, cls_pkg::ST_END);
    end else if (u == cls_pkg::U_DQUOTE) begin
      scan_st = cls_pkg::M_DQ;
      put_res(u, cls_pkg::ST_CHAR);
    end else if (u == cls_pkg::U_SQUOTE) begin
      scan_st = cls_pkg::M_SQ;
      put_res(u, cls_pkg::ST_CHAR);
    end else if (u == cls_pkg::U_SLASH) begin
      scan_st = cls_pkg::M_SLASH;
    end else begin
      scan_st = cls_pkg::M_NORMAL;
      put_res(u, cls_pkg::ST_CHAR);
    end
  endfunction

  function automatic void quoted_unit(input logic [cls_pkg::UnitW-1:0] u,
                                      input logic [cls_pkg::UnitW-1:0] quote,
                                      input cls_pkg::mode_t esc);
    if (u == cls_pkg::U_END) begin
      scan_st = cls_pkg::M_NORMAL;
      put_res(cls_pkg::U_END, cls_pkg::ST_UNCLOSED_LIT);
    end else if (u == cls_pkg::U_BSLASH) begin
      scan_st = esc;
      put_res(u, cls_pkg::ST_CHAR);
    end else if (u == cls_pkg::U_NL) begin
      scan_st = cls_pkg::M_ERR;
      put_res(cls_pkg::U_END, cls_pkg::ST_NL_LIT);
    end else begin
      if (u == quote) scan_st = cls_pkg::M_NORMAL;
      put_res(u, cls_pkg::ST_CHAR);
    end
  endfunction

  function automatic void strip_unit(input logic [cls_pkg::UnitW-1:0] u);
    step_res.delete();
    case (scan_st)
      cls_pkg::M_SLASH: begin
        if (u == cls_pkg::U_STAR) begin
          scan_st = cls_pkg::M_BLOCK;
        end else if (u == cls_pkg::U_SLASH) begin
          scan_st = cls_pkg::M_LINE;
        end else begin
          put_res(cls_pkg::U_SLASH, cls_pkg::ST_CHAR);
          plain_unit(u);
        end
      end
      cls_pkg::M_LINE: begin
        if (u == cls_pkg::U_END) begin
          scan_st = cls_pkg::M_NORMAL;
          put_res(cls_pkg::U_END, cls_pkg::ST_END);
        end else if (u == cls_pkg::U_NL) begin
          scan_st = cls_pkg::M_NORMAL;
        end
      end
      cls_pkg::M_BLOCK, cls_pkg::M_BSTAR: begin
        if (u == cls_pkg::U_END) begin
          scan_st = cls_pkg::M_NORMAL;
          put_res(cls_pkg::U_END, cls_pkg::ST_UNCLOSED_CMT);
        end else if (u == cls_pkg::U_STAR) begin
          scan_st = cls_pkg::M_BSTAR;
        end else if (u == cls_pkg::U_SLASH && scan_st == cls_pkg::M_BSTAR) begin
          scan_st = cls_pkg::M_NORMAL;
        end else begin
          scan_st = cls_pkg::M_BLOCK;
        end
      end
      cls_pkg::M_DQ: quoted_unit(u, cls_pkg::U_DQUOTE, cls_pkg::M_DQ_ESC);
      cls_pkg::M_SQ: quoted_unit(u, cls_pkg::U_SQUOTE, cls_pkg::M_SQ_ESC);
      cls_pkg::M_DQ_ESC, cls_pkg::M_SQ_ESC: begin
        if (u == cls_pkg::U_END) begin
          scan_st = cls_pkg::M_NORMAL;
          put_res(cls_pkg::U_END, cls_pkg::ST_UNCLOSED_LIT);
        end else begin
          scan_st = (scan_st == cls_pkg::M_DQ_ESC) ? cls_pkg::M_DQ : cls_pkg::M_SQ;
          put_res(u, cls_pkg::ST_CHAR);
        end
      end
      cls_pkg::M_ERR: begin
        if (u == cls_pkg::U_END) scan_st = cls_pkg::M_NORMAL;
      end
      default: plain_unit(u);
    endcase
    if (step_res.size() > 0) begin
      step_res[step_res.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void add_row(input logic [cls_pkg::UnitW-1:0] u, input int n,
                                  input logic [cls_pkg::UnitW-1:0] c0,
                                  input cls_pkg::status_t s0,
                                  input logic [cls_pkg::UnitW-1:0] c1,
                                  input cls_pkg::status_t s1);
    unit_row_t row;
    row.unit = u;
    row.n_fixed = n;
    row.r0.out_char = c0;
    row.r0.status = s0;
    row.r0.last = (n == 1);
    row.r1.out_char = c1;
    row.r1.status = s1;
    row.r1.last = 1'b1;
    unit_rows = {unit_rows, row};
  endfunction

  function automatic void add_unit(input logic [cls_pkg::UnitW-1:0] u);
    add_row(u, -1, cls_pkg::U_END, cls_pkg::ST_CHAR, cls_pkg::U_END, cls_pkg::ST_CHAR);
  endfunction

  function automatic logic [cls_pkg::UnitW-1:0] rand_plain();
    logic [cls_pkg::UnitW-1:0] u;
    do begin
      u = cls_pkg::UnitW'($urandom_range(32, 126));
    end while (u == cls_pkg::U_SLASH || u == cls_pkg::U_DQUOTE || u == cls_pkg::U_SQUOTE ||
               u == cls_pkg::U_BSLASH || u == cls_pkg::U_STAR);
    return u;
  endfunction

  function automatic logic [cls_pkg::UnitW-1:0] rand_any();
    logic [cls_pkg::UnitW-1:0] u;
    case ($urandom_range(0, 9))
      0: u = cls_pkg::U_STAR;
      1: u = cls_pkg::U_SLASH;
      2: u = cls_pkg::U_DQUOTE;
      3: u = cls_pkg::U_SQUOTE;
      4: u = cls_pkg::U_NL;
      5: u = cls_pkg::UnitW'($urandom_range(1, 65535));
      default: u = rand_plain();
    endcase
    return u;
  endfunction

  function automatic void add_literal_body(input logic [cls_pkg::UnitW-1:0] quote);
    int len;
    len = $urandom_range(0, 6);
    repeat (len) begin
      case ($urandom_range(0, 9))
        0: begin
          add_unit(cls_pkg::U_BSLASH);
          add_unit(rand_any());
        end
        1: begin
          add_unit(cls_pkg::U_BSLASH);
          add_unit(quote);
        end
        2: add_unit((quote == cls_pkg::U_DQUOTE) ? cls_pkg::U_SQUOTE : cls_pkg::U_DQUOTE);
        3: add_unit(cls_pkg::UnitW'($urandom_range(128, 65535)));
        default: add_unit(rand_plain());
      endcase
    end
  endfunction

  function automatic void add_comment_body(input bit line);
    int len;
    logic [cls_pkg::UnitW-1:0] u;
    len = $urandom_range(0, 6);
    repeat (len) begin
      u = rand_any();
      if (line && u == cls_pkg::U_NL) u = rand_plain();
      add_unit(u);
    end
  endfunction

  function automatic void add_token();
    logic [cls_pkg::UnitW-1:0] q;
    q = $urandom_range(0, 1) ? cls_pkg::U_DQUOTE : cls_pkg::U_SQUOTE;
    case ($urandom_range(0, 99)) inside
      [0:24]: repeat ($urandom_range(1, 5)) add_unit(rand_plain());
      [25:29]: add_unit(cls_pkg::UnitW'($urandom_range(1, 65535)));
      [30:39]: begin
        add_unit(cls_pkg::U_SLASH);
        add_unit(cls_pkg::U_STAR);
        add_comment_body(1'b0);
        add_unit(cls_pkg::U_STAR);
        add_unit(cls_pkg::U_SLASH);
      end
      [40:47]: begin
        add_unit(cls_pkg::U_SLASH);
        add_unit(cls_pkg::U_SLASH);
        add_comment_body(1'b1);
        add_unit(cls_pkg::U_NL);
      end
      [48:61]: begin
        add_unit(q);
        add_literal_body(q);
        add_unit(q);
      end
      [62:67]: add_unit(cls_pkg::U_NL);
      [68:72]: begin
        add_unit(cls_pkg::U_SLASH);
        case ($urandom_range(0, 3))
          0: add_unit(q);
          1: add_unit(cls_pkg::U_END);
          default: add_unit(rand_plain());
        endcase
      end
      [73:74]: add_unit(cls_pkg::U_STAR);
      [75:83]: add_unit(cls_pkg::U_END);
      [84:87]: begin
        add_unit(q);
        add_literal_body(q);
        add_unit(cls_pkg::U_NL);
        repeat ($urandom_range(0, 4)) add_unit(rand_any());
        add_unit(cls_pkg::U_END);
      end
      [88:90]: begin
        add_unit(q);
        add_literal_body(q);
        if ($urandom_range(0, 1)) add_unit(cls_pkg::U_BSLASH);
        add_unit(cls_pkg::U_END);
      end
      [91:94]: begin
        add_unit(cls_pkg::U_SLASH);
        add_unit(cls_pkg::U_STAR);
        add_comment_body(1'b0);
        if ($urandom_range(0, 1)) add_unit(cls_pkg::U_STAR);
        add_unit(cls_pkg::U_END);
      end
      [95:97]: begin
        add_unit(cls_pkg::U_SLASH);
        add_unit(cls_pkg::U_SLASH);
        add_comment_body(1'b1);
        add_unit(cls_pkg::U_END);
      end
      default: add_unit(cls_pkg::UnitW'($urandom_range(1, 65535)));
    endcase
  endfunction

  task automatic feed_units();
    unit_row_t row;
    int        gap;
    for (int idx = 0; idx < unit_rows.size(); idx++) begin
      row = unit_rows[idx];
      gap = (idx >= BurstFrom && idx < BurstTo) ? 0 : $urandom_range(0, MaxGap);
      if (gap > 0 || idx == DrainPauseAt) begin
        in_ch.valid <= 1'b0;
        if (idx == DrainPauseAt) begin
          wait (stripped_q.size() == 0);
          @(negedge clk);
        end
        repeat (gap) @(negedge clk);
      end
      in_ch.valid <= 1'b1;
      in_ch.code_unit <= row.unit;
      do @(posedge clk); while (!in_ch.ready);
      strip_unit(row.unit);
      if (row.n_fixed < 0) begin
        stripped_q = {stripped_q, step_res};
      end else begin
        if (row.n_fixed > 0) stripped_q = {stripped_q, row.r0};
        if (row.n_fixed > 1) stripped_q = {stripped_q, row.r1};
      end
      @(negedge clk);
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain_results();
    cls_pkg::res_t want;
    int            gap;
    forever begin
      if (got_cnt == LongHoldAt) begin
        gap = LongHold;
      end else if (got_cnt >= BurstFrom && got_cnt < BurstTo) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, MaxGap);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got_cnt++;
      if (stripped_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction: char %h status %0d last %0d", $time,
                 out_ch.out_char, out_ch.status, out_ch.last);
      end else begin
        want = stripped_q.pop_front();
        if (out_ch.out_char !== want.out_char) begin
          errors++;
          $display("%0t: out_char expected %h actual %h", $time, want.out_char,
                   out_ch.out_char);
        end
        if (out_ch.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_ch.status);
        end
        if (out_ch.last !== want.last) begin
          errors++;
          $display("%0t: last expected %0d actual %0d", $time, want.last, out_ch.last);
        end
      end
      @(negedge clk);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.code_unit = '0;
    out_ch.ready = 1'b0;
    errors = 0;
    got_cnt = 0;
    cycles = 0;
    scan_st = cls_pkg::M_NORMAL;

    add_row(16'h0061, 1, 16'h0061, cls_pkg::ST_CHAR, cls_pkg::U_END, cls_pkg::ST_CHAR);
    add_row(cls_pkg::U_END, 1, cls_pkg::U_END, cls_pkg::ST_END,
            cls_pkg::U_END, cls_pkg::ST_CHAR);
    add_row(16'hFFFF, 1, 16'hFFFF, cls_pkg::ST_CHAR, cls_pkg::U_END, cls_pkg::ST_CHAR);
    add_row(cls_pkg::U_SLASH, 0, cls_pkg::U_END, cls_pkg::ST_CHAR,
            cls_pkg::U_END, cls_pkg::ST_CHAR);
    add_row(16'h0078, 2, cls_pkg::U_SLASH, cls_pkg::ST_CHAR, 16'h0078, cls_pkg::ST_CHAR);
    add_unit(cls_pkg::U_SLASH);
    add_unit(cls_pkg::U_DQUOTE);
    add_unit(cls_pkg::U_BSLASH);
    add_row(cls_pkg::U_END, 1, cls_pkg::U_END, cls_pkg::ST_UNCLOSED_LIT,
            cls_pkg::U_END, cls_pkg::ST_CHAR);
    add_unit(cls_pkg::U_SQUOTE);
    add_row(cls_pkg::U_NL, 1, cls_pkg::U_END, cls_pkg::ST_NL_LIT,
            cls_pkg::U_END, cls_pkg::ST_CHAR);
    add_row(16'h0071, 0, cls_pkg::U_END, cls_pkg::ST_CHAR, cls_pkg::U_END, cls_pkg::ST_CHAR);
    add_row(cls_pkg::U_END, 0, cls_pkg::U_END, cls_pkg::ST_CHAR,
            cls_pkg::U_END, cls_pkg::ST_CHAR);
    add_unit(cls_pkg::U_SLASH);
    add_unit(cls_pkg::U_STAR);
    add_unit(cls_pkg::U_SLASH);
    add_unit(cls_pkg::U_STAR);
    add_unit(cls_pkg::U_SLASH);
    add_unit(cls_pkg::U_SLASH);
    add_unit(cls_pkg::U_SLASH);
    add_row(cls_pkg::U_END, 1, cls_pkg::U_END, cls_pkg::ST_END,
            cls_pkg::U_END, cls_pkg::ST_CHAR);
    add_unit(cls_pkg::U_SLASH);
    add_row(cls_pkg::U_END, 2, cls_pkg::U_SLASH, cls_pkg::ST_CHAR,
            cls_pkg::U_END, cls_pkg::ST_END);
    add_unit(cls_pkg::U_SLASH);
    add_unit(cls_pkg::U_STAR);
    add_row(cls_pkg::U_END, 1, cls_pkg::U_END, cls_pkg::ST_UNCLOSED_CMT,
            cls_pkg::U_END, cls_pkg::ST_CHAR);

    while (unit_rows.size() < RandomUnits) add_token();
    add_unit(cls_pkg::U_END);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    fork
      drain_results();
    join_none
    feed_units();
    wait (stripped_q.size() == 0);
    repeat (TailCycles) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
